### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/whe_pkg.sv
package whe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WIN_W    = 17;
  localparam int DIFF_W   = 18;
  localparam int SPAN_W   = 17;  // magnitude of a positive window span or offset

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  typedef logic signed [DIFF_W-1:0] whe_diff_t;

  typedef struct packed {
    logic      start;
    whe_diff_t offset;  // sample - window_low
    whe_diff_t span;    // window_high - window_low
  } whe_map_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } whe_map_stat_t;

endpackage

### rtl/whe_bin_map.sv
module whe_bin_map import whe_pkg::*; #(
  parameter int BINS  = 256,
  parameter int IDX_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  whe_map_req_t        req,
  output whe_map_stat_t       stat,
  output logic [IDX_W-1:0]    bin
);

  localparam int NUM_W = SPAN_W + IDX_W;
  localparam int CNT_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_CHK  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [1:0]        state;
  whe_diff_t         offset;
  whe_diff_t         span;
  logic [SPAN_W-1:0] rem;
  logic [IDX_W-1:0]  shreg;
  logic [CNT_W-1:0]  cnt;
  logic              done;

  logic [NUM_W-1:0]  num;
  logic [SPAN_W:0]   trial;
  logic              fits;

  // offset * BINS, valid when 0 <= offset < span
  assign num   = NUM_W'(offset[SPAN_W-1:0]) * NUM_W'(BINS);
  // restoring step: remainder stays below span, so one extra bit suffices
  assign trial = {rem, shreg[IDX_W-1]};
  assign fits  = trial >= {1'b0, span[SPAN_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            offset <= req.offset;
            span   <= req.span;
            state  <= M_CHK;
          end
        end
        M_CHK: begin
          if (span <= 0 || offset < 0) begin
            shreg <= '0;
            done  <= 1'b1;
            state <= M_IDLE;
          end else if (offset >= span) begin
            shreg <= IDX_W'(BINS - 1);
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            rem   <= num[NUM_W-1:IDX_W];
            shreg <= num[IDX_W-1:0];
            cnt   <= CNT_W'(IDX_W - 1);
            state <= M_DIV;
          end
        end
        M_DIV: begin
          rem   <= fits ? SPAN_W'(trial - {1'b0, span[SPAN_W-1:0]}) : trial[SPAN_W-1:0];
          shreg <= IDX_W'({shreg, fits});
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign bin       = shreg;
  assign stat.done = done;
  assign stat.busy = (state != M_IDLE);

endmodule

### rtl/windowed_histogram_engine.sv
// channel   dir  fields
// s_*       in   tuser: op; tdata: sample, read_index; tlast: last
// m_*       out  tdata: bin_num, bin_count, peak_count
// apb       in   window_low at 0x0, window_high at 0x4
//
// one item at a time; a read with an out-of-range index skips the count memory, and a
// sample is binned by a one-bit-per-cycle divider that a clamped sample skips
// reset starts a clearing pass over every bin of the count memory; no input is taken meanwhile
// a held result sits in the output register while the next item is already accepted
module windowed_histogram_engine import whe_pkg::*; #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sample[15:0], read_index[23:16]
  input  logic [1:0]  s_tuser,   // op[1:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // bin_num[7:0], bin_count[39:8], peak_count[71:40]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  // configuration
  logic signed [WIN_W-1:0] win_low;
  logic signed [WIN_W-1:0] win_high;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_low  <= WIN_W'(0);
      win_high <= WIN_W'(255);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) win_high <= pwdata[WIN_W-1:0];
      else          win_low  <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2]) prdata = {{(32-WIN_W){win_high[WIN_W-1]}}, win_high};
    else          prdata = {{(32-WIN_W){win_low[WIN_W-1]}}, win_low};
  end

  // input fields
  logic signed [SAMPLE_W-1:0] smp;
  logic [7:0]                 read_index;
  logic [1:0]                 op;
  logic                       s_xfer;

  assign smp        = s_tdata[15:0];
  assign read_index = s_tdata[23:16];
  assign op         = s_tuser;
  assign s_xfer     = s_tvalid && s_tready;

  // control and result registers
  logic [2:0]            state;
  logic [IDX_W-1:0]      clr_addr;
  logic                  clr_emit;
  logic                  is_rmw;
  logic [IDX_W-1:0]      rd_addr;
  logic [7:0]            res_idx;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [COUNT_BITS-1:0] peak;

  // count memory
  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] mem_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] cnt_inc;

  // bin mapping unit
  whe_map_req_t     map_req;
  whe_map_stat_t    map_stat;
  logic [IDX_W-1:0] map_bin;

  assign map_req.start  = s_xfer && (op == OP_SAMPLE);
  assign map_req.offset = DIFF_W'(smp) - DIFF_W'(win_low);
  assign map_req.span   = DIFF_W'(win_high) - DIFF_W'(win_low);

  whe_bin_map #(
    .BINS  (BINS),
    .IDX_W (IDX_W)
  ) u_map (
    .clk  (clk),
    .rst  (rst),
    .req  (map_req),
    .stat (map_stat),
    .bin  (map_bin)
  );

  assign s_tready = (state == S_IDLE);

  // saturating increment
  assign cnt_inc   = (&mem_q) ? mem_q : mem_q + 1'b1;
  assign mem_we    = (state == S_CLR) || (state == S_UPD && is_rmw);
  assign mem_waddr = (state == S_CLR) ? clr_addr : rd_addr;
  assign mem_wdata = (state == S_CLR) ? '0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state == S_RD) mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      clr_emit <= 1'b0;
      peak     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      case (state)
        S_CLR: begin
          if (clr_addr == IDX_W'(BINS - 1)) begin
            peak     <= '0;
            res_idx  <= '0;
            res_cnt  <= '0;
            clr_addr <= '0;
            state    <= clr_emit ? S_EMIT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (s_xfer) begin
            case (op)
              OP_CLEAR: begin
                clr_addr <= '0;
                clr_emit <= 1'b1;
                state    <= S_CLR;
              end
              OP_SAMPLE: begin
                is_rmw <= 1'b1;
                state  <= S_MAP;
              end
              default: begin
                // read, and the unused code answers as a read
                is_rmw  <= 1'b0;
                res_idx <= read_index;
                rd_addr <= IDX_W'(read_index);
                res_cnt <= '0;
                state   <= (32'(read_index) < 32'(BINS)) ? S_RD : S_EMIT;
              end
            endcase
          end
        end
        S_MAP: begin
          if (map_stat.done) begin
            rd_addr <= map_bin;
            res_idx <= 8'(map_bin);
            state   <= S_RD;
          end
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          if (is_rmw) begin
            res_cnt <= cnt_inc;
            if (cnt_inc > peak) peak <= cnt_inc;
          end else begin
            res_cnt <= mem_q;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!m_tvalid || m_tready)) begin
      m_tdata <= {32'(peak), 32'(res_cnt), res_idx};
    end
  end

  // s_tlast marks the end of a data set and leaves the histogram untouched

  `ASSERT_NXT(a_busy_after_accept, clk, rst, s_xfer, !s_tready)
  `ASSERT_IMP(a_map_idle_when_ready, clk, rst, s_tready, !map_stat.busy)
  `ASSERT_NXT(a_peak_covers_result, clk, rst, state == S_UPD, peak >= res_cnt)
  `ASSERT_IMP(a_result_from_emit, clk, rst, $rose(m_tvalid), $past(state) == S_EMIT)

endmodule

### tb/tb_windowed_histogram_engine.sv
module tb_windowed_histogram_engine;
  import whe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BINS = 256;
  localparam logic [1:0] OP_SPARE = 2'd3;  // unused code, behaves as a read
  localparam logic [2:0] ADDR_WIN_LO = 3'd0;
  localparam logic [2:0] ADDR_WIN_HI = 3'd4;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_DIRECTED = 20;

  typedef struct packed {
    logic [7:0]  bin_num;
    logic [31:0] bin_count;
    logic [31:0] peak_count;
  } hist_result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sample;
    logic [7:0]         read_index;
    logic               last;
    logic               typed;  // expected result given in the row
    hist_result_t       res;
  } hist_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // sample[15:0], read_index[23:16]
  logic [1:0]  s_tuser = OP_CLEAR;  // op[1:0]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // bin_num[7:0], bin_count[39:8], peak_count[71:40]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = ADDR_WIN_LO;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  windowed_histogram_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // histogram mirror
  logic [31:0]        hist_bins [NUM_BINS];
  logic [31:0]        hist_peak;
  logic signed [16:0] win_lo;
  logic signed [16:0] win_hi;

  hist_result_t pending_q [$];
  int snd_idle_pct;
  int rcv_idle_pct;
  int error_count;
  int results_seen;
  int n_items, n_clears, n_samples, n_reads;
  logic [7:0] last_bin;

  function automatic logic [7:0] window_bin(logic signed [15:0] smp);
    longint den;
    longint num;
    longint q;
    den = longint'(win_hi) - longint'(win_lo);
    if (den <= 0) return 8'd0;
    num = (longint'(smp) - longint'(win_lo)) * NUM_BINS;
    if (num < 0) return 8'd0;
    q = num / den;
    if (q > NUM_BINS - 1) q = NUM_BINS - 1;
    return q[7:0];
  endfunction

  function automatic hist_result_t apply_item(logic [1:0] op, logic signed [15:0] smp,
                                              logic [7:0] ridx);
    hist_result_t r;
    logic [7:0] b;
    case (op)
      OP_CLEAR: begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        hist_peak = '0;
        r = '{8'd0, 32'd0, 32'd0};
        n_clears++;
      end
      OP_SAMPLE: begin
        b = window_bin(smp);
        if (hist_bins[b] != '1) hist_bins[b] = hist_bins[b] + 1;
        if (hist_bins[b] > hist_peak) hist_peak = hist_bins[b];
        r = '{b, hist_bins[b], hist_peak};
        last_bin = b;
        n_samples++;
      end
      default: begin
        r = '{ridx, hist_bins[ridx], hist_peak};
        n_reads++;
      end
    endcase
    return r;
  endfunction

  task automatic feed_item(input logic [1:0] op, input logic signed [15:0] smp,
                           input logic [7:0] ridx, input logic lst,
                           input logic typed, input hist_result_t typed_res);
    hist_result_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ridx, smp};
    s_tuser  <= op;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    r = apply_item(op, smp, ridx);
    if (typed) r = typed_res;
    pending_q.push_back(r);
    n_items++;
  endtask

  task automatic write_window(input logic [2:0] addr, input logic signed [16:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{15{val[16]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_WIN_LO) win_lo = val;
    else win_hi = val;
  endtask

  // result side: random backpressure and in-order compare
  always @(posedge clk) begin
    hist_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          if (error_count < 10)
            $display("ERROR: unexpected result idx=%0d count=%0d peak=%0d",
                     m_tdata[7:0], m_tdata[39:8], m_tdata[71:40]);
          error_count++;
        end else begin
          want = pending_q.pop_front();
          if (m_tdata[7:0] !== want.bin_num || m_tdata[39:8] !== want.bin_count ||
              m_tdata[71:40] !== want.peak_count) begin
            if (error_count < 10)
              $display("ERROR: result %0d expected idx=%0d count=%0d peak=%0d, got idx=%0d count=%0d peak=%0d",
                       results_seen, want.bin_num, want.bin_count, want.peak_count,
                       m_tdata[7:0], m_tdata[39:8], m_tdata[71:40]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("ERROR: run timed out");
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    hist_row_t dir_rows [NUM_DIRECTED];
    logic signed [16:0] phase_lo [NUM_PHASES];
    logic signed [16:0] phase_hi [NUM_PHASES];
    int snd_pct [3];
    int rcv_pct [3];
    int lo_v, hi_v, pick;
    logic [1:0] op;
    logic signed [15:0] smp;
    logic [7:0] ridx;

    dir_rows = '{
      '{OP_READ,   16'sh0000, 8'd0,   1'b0, 1'b1, '{8'd0,   32'd0, 32'd0}},
      '{OP_READ,   16'sh0000, 8'd255, 1'b0, 1'b1, '{8'd255, 32'd0, 32'd0}},
      '{OP_SPARE,  16'sh0000, 8'd17,  1'b0, 1'b1, '{8'd17,  32'd0, 32'd0}},
      '{OP_SAMPLE, 16'sh0000, 8'd0,   1'b0, 1'b0, '0},
      '{OP_SAMPLE, 16'sh8000, 8'd0,   1'b0, 1'b0, '0},  // far below the window
      '{OP_SAMPLE, 16'sh7fff, 8'd0,   1'b0, 1'b0, '0},  // far above the window
      '{OP_SAMPLE, 16'sh00ff, 8'd0,   1'b0, 1'b0, '0},  // window top clamps
      '{OP_SAMPLE, 16'sh00fe, 8'd0,   1'b0, 1'b0, '0},
      '{OP_SAMPLE, 16'shffff, 8'd0,   1'b0, 1'b0, '0},
      '{OP_SAMPLE, 16'sh0080, 8'd0,   1'b1, 1'b0, '0},
      '{OP_READ,   16'sh0000, 8'd0,   1'b0, 1'b0, '0},
      '{OP_READ,   16'sh0000, 8'd255, 1'b0, 1'b0, '0},
      '{OP_READ,   16'sh0000, 8'd254, 1'b0, 1'b0, '0},
      '{OP_SPARE,  16'sh7fff, 8'd0,   1'b1, 1'b0, '0},
      '{OP_CLEAR,  16'sh1234, 8'd99,  1'b1, 1'b1, '{8'd0,   32'd0, 32'd0}},
      '{OP_READ,   16'sh0000, 8'd0,   1'b0, 1'b1, '{8'd0,   32'd0, 32'd0}},
      '{OP_READ,   16'sh0000, 8'd255, 1'b0, 1'b1, '{8'd255, 32'd0, 32'd0}},
      '{OP_SAMPLE, 16'sh5555, 8'haa,  1'b1, 1'b0, '0},
      '{OP_SAMPLE, 16'shaaaa, 8'h55,  1'b0, 1'b0, '0},
      '{OP_READ,   16'sh0000, 8'haa,  1'b0, 1'b0, '0}
    };
    // full range, equal bounds, inverted bounds, narrow, random, one-wide
    phase_lo = '{-17'sd32818, 17'sd100, 17'sd32817,  -17'sd50, 17'sd0, -17'sd32768};
    phase_hi = '{17'sd32817,  17'sd100, -17'sd32818, 17'sd77,  17'sd0, -17'sd32767};
    snd_pct = '{10, 73, 0};
    rcv_pct = '{73, 10, 0};

    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_peak = '0;
    win_lo = 17'sd0;
    win_hi = 17'sd255;
    last_bin = '0;
    error_count = 0;
    results_seen = 0;
    n_items = 0;
    n_clears = 0;
    n_samples = 0;
    n_reads = 0;
    snd_idle_pct = snd_pct[0];
    rcv_idle_pct = rcv_pct[0];

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      feed_item(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].read_index,
                dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      s_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clk);
      if (p == 4) begin
        phase_lo[p] = 17'($signed($urandom_range(65635)) - 32818);
        phase_hi[p] = 17'($signed($urandom_range(65635)) - 32818);
      end
      write_window(ADDR_WIN_LO, phase_lo[p]);
      write_window(ADDR_WIN_HI, phase_hi[p]);
      snd_idle_pct = snd_pct[p / 2];
      rcv_idle_pct = rcv_pct[p / 2];
      // span the window with a small margin, kept in the sample range
      lo_v = (int'(win_lo) < int'(win_hi) ? int'(win_lo) : int'(win_hi)) - 4;
      hi_v = (int'(win_lo) < int'(win_hi) ? int'(win_hi) : int'(win_lo)) + 4;
      if (lo_v < -32768) lo_v = -32768;
      if (hi_v > 32767) hi_v = 32767;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(99);
        if (pick < 3) op = OP_CLEAR;
        else if (pick < 65) op = OP_SAMPLE;
        else if (pick < 92) op = OP_READ;
        else op = OP_SPARE;
        if ($urandom_range(3) == 0) smp = 16'($urandom);
        else smp = 16'(lo_v + int'($urandom_range(hi_v - lo_v)));
        ridx = $urandom_range(1) ? last_bin : 8'($urandom);
        feed_item(op, smp, ridx, ($urandom_range(7) == 0), 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (NUM_BINS + 16) @(posedge clk);
    if (pending_q.size() != 0) begin
      $display("ERROR: %0d results never arrived", pending_q.size());
      error_count++;
    end

    $display("checked %0d results for %0d transfers: %0d clears, %0d samples, %0d reads",
             results_seen, n_items, n_clears, n_samples, n_reads);
    $display("window settings: default, full range, equal, inverted, narrow, random, one wide");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/whe_pkg.sv
rtl/whe_bin_map.sv
rtl/windowed_histogram_engine.sv
tb/tb_windowed_histogram_engine.sv
